[design/ell_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ell_pkg
// Token kinds, token record types and keyword lookup for the lexer.
// ----------------------------------------------------------------------------
package ell_pkg;

  localparam int TEXT_BYTES = 16;

  localparam logic [4:0] K_END    = 5'd0;
  localparam logic [4:0] K_INT    = 5'd1;
  localparam logic [4:0] K_IDENT  = 5'd2;
  localparam logic [4:0] K_PLUS   = 5'd3;
  localparam logic [4:0] K_MINUS  = 5'd4;
  localparam logic [4:0] K_STAR   = 5'd5;
  localparam logic [4:0] K_SLASH  = 5'd6;
  localparam logic [4:0] K_LPAR   = 5'd7;
  localparam logic [4:0] K_RPAR   = 5'd8;
  localparam logic [4:0] K_SEMI   = 5'd9;
  localparam logic [4:0] K_ASSIGN = 5'd10;
  localparam logic [4:0] K_EQEQ   = 5'd11;
  localparam logic [4:0] K_BANG   = 5'd12;
  localparam logic [4:0] K_NEQ    = 5'd13;
  localparam logic [4:0] K_LT     = 5'd14;
  localparam logic [4:0] K_GT     = 5'd15;
  localparam logic [4:0] K_LE     = 5'd16;
  localparam logic [4:0] K_GE     = 5'd17;
  localparam logic [4:0] K_ANDAND = 5'd18;
  localparam logic [4:0] K_OROR   = 5'd19;
  localparam logic [4:0] K_KW0    = 5'd20;
  localparam logic [4:0] K_ERROR  = 5'd29;

  localparam logic [30:0] INT_SAT = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [4:0]   kind;
    logic [30:0]  value;
    logic [127:0] text;
    logic [4:0]   len;
    logic [15:0]  line;
    logic [15:0]  col;
    logic         last;
  } tok_t;

  typedef struct packed {
    logic [1:0] cnt;
    tok_t       rec0;
    tok_t       rec1;
  } push_t;

  // Keywords stored last character first, so byte j holds character j.
  localparam logic [79:0] KW_TEXT [9] = '{
    80'("eril"), 80'("erirce"), 80'("is"), 80'("srola"), 80'("nonis"),
    80'("isnif"), 80'("euqtnat"), 80'("eriaf"), 80'("euqtnatnif")
  };
  localparam logic [4:0] KW_LEN [9] = '{
    5'd4, 5'd6, 5'd2, 5'd5, 5'd5, 5'd5, 5'd7, 5'd5, 5'd10
  };

  // Text above the count is always zero, so a full compare is exact.
  function automatic logic [4:0] kw_kind(input logic [127:0] text,
                                         input logic [4:0] count);
    logic [4:0] k;
    k = K_IDENT;
    for (int i = 8; i >= 0; i--) begin
      if (count == KW_LEN[i] && text == {48'd0, KW_TEXT[i]}) begin
        k = K_KW0 + 5'(i);
      end
    end
    return k;
  endfunction

endpackage

[design/ell_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ell_front
// Character classifier and pending-token state; emits up to two token
// records per accepted character into the queue.
// ----------------------------------------------------------------------------
module ell_front #(
  parameter int MAX_TEXT = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     char_code,
  input  logic           end_mark,
  input  logic [15:0]    line_number,
  input  logic [15:0]    column_number,
  input  logic           space2,
  output ell_pkg::push_t push
);
  import ell_pkg::*;

  localparam logic [2:0] M_IDLE  = 3'd0;
  localparam logic [2:0] M_INT   = 3'd1;
  localparam logic [2:0] M_IDENT = 3'd2;
  localparam logic [2:0] M_EQ    = 3'd3;
  localparam logic [2:0] M_BANG  = 3'd4;
  localparam logic [2:0] M_COMP  = 3'd5;
  localparam logic [2:0] M_AND   = 3'd6;
  localparam logic [2:0] M_OR    = 3'd7;

  logic [2:0]   mode, mode_next;
  logic [4:0]   pkind, pkind_next;
  logic [30:0]  acc, acc_next;
  logic [127:0] text, text_next;
  logic [4:0]   tcount, tcount_next;
  logic [15:0]  tline, tline_next;
  logic [15:0]  tcol, tcol_next;
  logic         halted, halted_next;

  logic         accept;
  logic         is_digit, is_letter;
  logic [3:0]   dval;
  logic [34:0]  prod;
  logic         fl_v, fl_err;
  tok_t         fl_rec, rec_a, rec_b;
  logic         a_v, b_v, consumed;
  logic [4:0]   single;

  assign in_ready  = space2;
  assign accept    = in_valid && space2;
  assign is_digit  = char_code >= "0" && char_code <= "9";
  assign is_letter = (char_code >= "a" && char_code <= "z") ||
                     (char_code >= "A" && char_code <= "Z");
  assign dval      = 4'(char_code - "0");
  assign prod      = {1'b0, acc, 3'd0} + {3'd0, acc, 1'b0} + {31'd0, dval};

  always_comb begin
    fl_v   = mode != M_IDLE;
    fl_err = 1'b0;
    fl_rec = '0;
    fl_rec.text = text;
    fl_rec.len  = tcount;
    fl_rec.line = tline;
    fl_rec.col  = tcol;
    unique case (mode)
      M_INT: begin
        fl_rec.kind  = K_INT;
        fl_rec.value = acc;
      end
      M_IDENT: fl_rec.kind = kw_kind(text, tcount);
      M_AND, M_OR: begin
        fl_rec.kind = K_ERROR;
        fl_err = 1'b1;
      end
      M_EQ, M_BANG, M_COMP: fl_rec.kind = pkind;
      default: fl_rec.kind = K_END;
    endcase
  end

  always_comb begin
    case (char_code)
      "+":     single = K_PLUS;
      "-":     single = K_MINUS;
      "*":     single = K_STAR;
      "/":     single = K_SLASH;
      "(":     single = K_LPAR;
      ")":     single = K_RPAR;
      ";":     single = K_SEMI;
      default: single = K_END;
    endcase
  end

  always_comb begin
    mode_next   = mode;
    pkind_next  = pkind;
    acc_next    = acc;
    text_next   = text;
    tcount_next = tcount;
    tline_next  = tline;
    tcol_next   = tcol;
    halted_next = halted;
    a_v = 1'b0;
    b_v = 1'b0;
    consumed = 1'b0;
    rec_a = '0;
    rec_b = '0;
    rec_b.line = line_number;
    rec_b.col  = column_number;
    if (end_mark) begin
      if (!halted) begin
        a_v   = fl_v;
        rec_a = fl_rec;
      end
      b_v = 1'b1;
      rec_b.kind  = K_END;
      mode_next   = M_IDLE;
      pkind_next  = '0;
      acc_next    = '0;
      text_next   = '0;
      tcount_next = '0;
      tline_next  = '0;
      tcol_next   = '0;
      halted_next = 1'b0;
    end else if (!halted) begin
      rec_a.text = text;
      rec_a.len  = tcount;
      rec_a.line = tline;
      rec_a.col  = tcol;
      unique case (mode)
        M_INT, M_IDENT: begin
          if (is_digit || (mode == M_IDENT && is_letter)) begin
            consumed = 1'b1;
            if (32'(tcount) >= MAX_TEXT) begin
              a_v = 1'b1;
              rec_a.kind  = K_ERROR;
              halted_next = 1'b1;
            end else begin
              text_next[8*tcount[3:0] +: 8] = char_code;
              tcount_next = tcount + 5'd1;
              if (mode == M_INT) begin
                acc_next = (prod > 35'(INT_SAT)) ? INT_SAT : prod[30:0];
              end
            end
          end
        end
        M_EQ, M_BANG, M_COMP, M_AND, M_OR: begin
          if ((mode == M_AND && char_code == "&") ||
              (mode == M_OR && char_code == "|") ||
              (mode != M_AND && mode != M_OR && char_code == "=")) begin
            consumed = 1'b1;
            a_v = 1'b1;
            rec_a.text[15:8] = char_code;
            rec_a.len = 5'd2;
            case (pkind)
              K_ASSIGN: rec_a.kind = K_EQEQ;
              K_BANG:   rec_a.kind = K_NEQ;
              K_LT:     rec_a.kind = K_LE;
              K_GT:     rec_a.kind = K_GE;
              default:  rec_a.kind = (mode == M_AND) ? K_ANDAND : K_OROR;
            endcase
          end
        end
        default: consumed = 1'b0;
      endcase
      if (consumed && a_v) begin
        mode_next   = M_IDLE;
        pkind_next  = '0;
        acc_next    = '0;
        text_next   = '0;
        tcount_next = '0;
      end
      if (!consumed) begin
        a_v   = fl_v;
        rec_a = fl_rec;
        mode_next   = M_IDLE;
        pkind_next  = '0;
        acc_next    = '0;
        text_next   = '0;
        tcount_next = '0;
        if (fl_err) begin
          halted_next = 1'b1;
        end else begin
          rec_b.text = {120'd0, char_code};
          rec_b.len  = 5'd1;
          if (single != K_END) begin
            b_v = 1'b1;
            rec_b.kind = single;
          end else if (char_code == " " || char_code == 8'h09 ||
                       char_code == 8'h0A) begin
            b_v = 1'b0;
          end else if (char_code == "=" || char_code == "!" || char_code == "<" ||
                       char_code == ">" || char_code == "&" || char_code == "|" ||
                       is_digit || is_letter) begin
            text_next   = {120'd0, char_code};
            tcount_next = 5'd1;
            tline_next  = line_number;
            tcol_next   = column_number;
            if (is_digit) begin
              mode_next  = M_INT;
              pkind_next = K_INT;
              acc_next   = {27'd0, dval};
            end else if (is_letter) begin
              mode_next  = M_IDENT;
              pkind_next = K_IDENT;
            end else if (char_code == "=") begin
              mode_next  = M_EQ;
              pkind_next = K_ASSIGN;
            end else if (char_code == "!") begin
              mode_next  = M_BANG;
              pkind_next = K_BANG;
            end else if (char_code == "<") begin
              mode_next  = M_COMP;
              pkind_next = K_LT;
            end else if (char_code == ">") begin
              mode_next  = M_COMP;
              pkind_next = K_GT;
            end else if (char_code == "&") begin
              mode_next  = M_AND;
            end else begin
              mode_next  = M_OR;
            end
          end else begin
            b_v = 1'b1;
            rec_b.kind  = K_ERROR;
            halted_next = 1'b1;
            tline_next  = line_number;
            tcol_next   = column_number;
          end
        end
      end
    end
  end

  always_comb begin
    push = '0;
    if (accept) begin
      push.cnt = {1'b0, a_v} + {1'b0, b_v};
      if (a_v) begin
        push.rec0 = rec_a;
        push.rec1 = rec_b;
        push.rec0.last = !b_v;
        push.rec1.last = 1'b1;
      end else begin
        push.rec0 = rec_b;
        push.rec0.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      pkind  <= '0;
      acc    <= '0;
      text   <= '0;
      tcount <= '0;
      tline  <= '0;
      tcol   <= '0;
      halted <= 1'b0;
    end else if (accept) begin
      mode   <= mode_next;
      pkind  <= pkind_next;
      acc    <= acc_next;
      text   <= text_next;
      tcount <= tcount_next;
      tline  <= tline_next;
      tcol   <= tcol_next;
      halted <= halted_next;
    end
  end

  a_halt_clear: assert property (@(posedge clk) disable iff (rst)
    halted |-> (mode == M_IDLE && tcount == 5'd0))
    else $error("halted with a pending token");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    32'(tcount) <= MAX_TEXT)
    else $error("token text over limit");
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (mode == M_IDLE) |-> (tcount == 5'd0 && acc == 31'd0))
    else $error("idle with stale token state");
  a_push_accept: assert property (@(posedge clk) disable iff (rst)
    (push.cnt != 2'd0) |-> (in_valid && space2))
    else $error("push without transfer");

endmodule

[design/ell_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ell_queue
// Four-entry token queue: up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module ell_queue (
  input  logic           clk,
  input  logic           rst,
  input  ell_pkg::push_t push,
  output logic           space2,
  output logic           rd_valid,
  output ell_pkg::tok_t  rd_data,
  input  logic           pop
);
  import ell_pkg::*;

  tok_t       mem [4];
  logic [1:0] wptr, rptr;
  logic [2:0] count;

  assign space2   = count <= 3'd2;
  assign rd_valid = count != 3'd0;
  assign rd_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wptr] <= push.rec0;
    end
    if (push.cnt == 2'd2) begin
      mem[wptr + 2'd1] <= push.rec1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + push.cnt;
      rptr  <= rptr + {1'b0, pop};
      count <= count + {1'b0, push.cnt} - {2'd0, pop};
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4)
    else $error("queue overflow");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.cnt != 2'd0) |-> space2)
    else $error("push without room");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> rd_valid)
    else $error("pop from empty queue");

endmodule

[design/ell_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ell_back
// Output register: takes tokens from the queue and presents them downstream.
// ----------------------------------------------------------------------------
module ell_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_valid,
  input  ell_pkg::tok_t rd_data,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output ell_pkg::tok_t out_rec
);
  import ell_pkg::*;

  logic load;

  assign load = !out_valid || out_ready;
  assign pop  = rd_valid && load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_rec <= rd_data;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output dropped under stall");
  a_pop_free: assert property (@(posedge clk) disable iff (rst)
    pop |-> (!out_valid || out_ready))
    else $error("pop into a full output register");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid)
    else $error("popped token not shown");

endmodule

[design/expression_language_lexer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expression_language_lexer
// Streaming lexer: one character per transfer in, token records out.
// ----------------------------------------------------------------------------
// Path: the classifier writes a completed token into the token queue, then
// the output register presents it to the downstream side.
// Throughput: one character per cycle while the token queue has room for two
// records; the tokens of one character leave one at a time via the four-entry queue.
// Reset: synchronous rst clears lexer state, queue pointers and output valid.
module expression_language_lexer #(
  parameter int MAX_TEXT = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,  // char_code, line_number, column_number
  input  logic         s_axis_tlast,  // end_mark
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [199:0] m_axis_tdata,  // int_value, text_low, text_high,
                                      // text_length, start_line, start_column
  output logic [4:0]   m_axis_tuser,  // token_kind
  output logic         m_axis_tlast   // last_of_run
);
  import ell_pkg::*;

  push_t push;
  logic  space2, rd_valid, pop;
  tok_t  rd_data, out_rec;

  ell_front #(.MAX_TEXT(MAX_TEXT)) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .char_code     (s_axis_tdata[7:0]),
    .end_mark      (s_axis_tlast),
    .line_number   (s_axis_tdata[23:8]),
    .column_number (s_axis_tdata[39:24]),
    .space2        (space2),
    .push          (push)
  );

  ell_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .space2   (space2),
    .rd_valid (rd_valid),
    .rd_data  (rd_data),
    .pop      (pop)
  );

  ell_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rd_valid  (rd_valid),
    .rd_data   (rd_data),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_rec   (out_rec)
  );

  assign m_axis_tdata = {4'd0, out_rec.col, out_rec.line, out_rec.len,
                         out_rec.text[127:64], out_rec.text[63:0], out_rec.value};
  assign m_axis_tuser = out_rec.kind;
  assign m_axis_tlast = out_rec.last;

endmodule
